// ----- hw/rtl/pfs_pkg.sv -----
// Shared types, constants and the base-rate table for the PLL factor search.
// No dependencies; every other file in hw/rtl imports this package.
`timescale 1ns / 1ps

package pfs_pkg;

    // factor ranges
    localparam int N_MAX = 32;
    localparam int K_MAX = 4;
    localparam int M_MAX = 4;

    // field widths
    localparam int N_W    = 5;
    localparam int K_W    = 2;
    localparam int M_W    = 2;
    localparam int P_W    = 2;
    localparam int RATE_W = 32;
    localparam int BASE_W = 25;
    localparam int NK_W   = 8;

    // highest post divider exponent for low targets
    localparam logic [P_W-1:0] P_TOP_LOW = 2'd2;

    // reference clock and the post divider limit
    localparam logic [BASE_W-1:0] BASE_HZ    = 25'd24000000;
    localparam logic [RATE_W-1:0] P_LIMIT_HZ = 32'd288000000;

    // last code of each factor
    localparam logic [N_W-1:0] N_LAST = N_W'(N_MAX - 1);
    localparam logic [K_W-1:0] K_LAST = K_W'(K_MAX - 1);
    localparam logic [M_W-1:0] M_LAST = M_W'(M_MAX - 1);

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_RUN,
        SEQ_WAIT
    } seq_state_t;

    // one candidate combination from the sequencer
    typedef struct packed {
        logic           valid;
        logic           last;
        logic [N_W-1:0] n_code;
        logic [K_W-1:0] k_code;
        logic [M_W-1:0] m_code;
        logic [P_W-1:0] p_code;
    } cand_t;

    // one evaluated candidate with its rate
    typedef struct packed {
        logic              valid;
        logic              last;
        logic [N_W-1:0]    n_code;
        logic [K_W-1:0]    k_code;
        logic [M_W-1:0]    m_code;
        logic [P_W-1:0]    p_code;
        logic [RATE_W-1:0] rate;
    } rate_t;

    // 24 MHz / (M * 2^P); exact since 24 MHz divides by every M * 2^P used
    function automatic logic [BASE_W-1:0] base_rate(
        input logic [M_W-1:0] m_code,
        input logic [P_W-1:0] p_code
    );
        logic [BASE_W-1:0] div_m;
        case (m_code)
            2'd0:    div_m = 25'd24000000;
            2'd1:    div_m = 25'd12000000;
            2'd2:    div_m = 25'd8000000;
            default: div_m = 25'd6000000;
        endcase
        return div_m >> p_code;
    endfunction

endpackage

// ----- hw/rtl/pll_factor_search.sv -----
// Top level of the PLL factor search: input capture, output register and
// the sequencer, rate unit and best-fit tracker. Depends on pfs_pkg.
`timescale 1ns / 1ps

// Usage
// - input channel: target_hz with in_valid / in_ready; a transfer starts a
//   search. in_ready is high only while no search is running.
// - output channel: n_code, k_code, m_code, p_code, achieved_hz, fit_found
//   with out_valid / out_ready; one result per input transfer.
// - one candidate combination is evaluated per cycle by a single table and
//   multiplier unit stepped by the sequencer over K, N, M and P.
// - targets below 288 MHz take 1536 candidates, others 512 (P held at 0).
// - out_valid follows an input transfer after the candidate sweep, the
//   two rate unit stages, the best-fit update and the output load;
//   in_ready returns the cycle after the load.
// - when nothing fits, all codes and achieved_hz are zero and fit_found is 0.
// - a stalled receiver holds the result in the output register; the next
//   item may be taken and searched meanwhile, but its result waits until
//   the held one is transferred.
// - reset clears the sequencer and the valid flags; the block is then idle.
module pll_factor_search
    import pfs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [RATE_W-1:0] target_hz,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [N_W-1:0]    n_code,
    output logic [K_W-1:0]    k_code,
    output logic [M_W-1:0]    m_code,
    output logic [P_W-1:0]    p_code,
    output logic [RATE_W-1:0] achieved_hz,
    output logic              fit_found
);

    logic              start;
    logic              idle;
    logic              load;
    logic              done;
    logic              out_free;
    logic [RATE_W-1:0] target_reg;
    logic [P_W-1:0]    p_top_reg;
    cand_t             cand;
    rate_t             rate_w;
    logic              b_found;
    logic [N_W-1:0]    b_n;
    logic [K_W-1:0]    b_k;
    logic [M_W-1:0]    b_m;
    logic [P_W-1:0]    b_p;
    logic [RATE_W-1:0] b_rate;
    logic              out_valid_reg;
    logic [N_W-1:0]    n_code_reg;
    logic [K_W-1:0]    k_code_reg;
    logic [M_W-1:0]    m_code_reg;
    logic [P_W-1:0]    p_code_reg;
    logic [RATE_W-1:0] achieved_reg;
    logic              fit_reg;

    assign in_ready = idle;
    assign start    = in_valid && idle;
    assign out_free = !out_valid_reg || out_ready;

    // capture the target and the P range on input transfer
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            target_reg <= target_hz;
            p_top_reg  <= (target_hz < P_LIMIT_HZ) ? P_TOP_LOW : '0;
        end
    end

    pfs_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .p_top    (p_top_reg),
        .done     (done),
        .out_free (out_free),
        .idle     (idle),
        .load     (load),
        .cand     (cand)
    );

    pfs_rate_unit u_rate (
        .clk      (clk),
        .rst_n    (rst_n),
        .cand     (cand),
        .rate_out (rate_w)
    );

    pfs_best u_best (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .target  (target_reg),
        .rate_in (rate_w),
        .done    (done),
        .found   (b_found),
        .n_code  (b_n),
        .k_code  (b_k),
        .m_code  (b_m),
        .p_code  (b_p),
        .rate    (b_rate)
    );

    // output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            n_code_reg   <= b_n;
            k_code_reg   <= b_k;
            m_code_reg   <= b_m;
            p_code_reg   <= b_p;
            achieved_reg <= b_rate;
            fit_reg      <= b_found;
        end
    end

    assign out_valid   = out_valid_reg;
    assign n_code      = n_code_reg;
    assign k_code      = k_code_reg;
    assign m_code      = m_code_reg;
    assign p_code      = p_code_reg;
    assign achieved_hz = achieved_reg;
    assign fit_found   = fit_reg;

endmodule

// ----- hw/rtl/pfs_seq.sv -----
// Sequencer for the PLL factor search: walks K, N, M, P in search order
// and hands off the final result. Depends on pfs_pkg.
`timescale 1ns / 1ps

module pfs_seq
    import pfs_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [P_W-1:0] p_top,
    input  logic           done,
    input  logic           out_free,
    output logic           idle,
    output logic           load,
    output cand_t          cand
);

    seq_state_t     state_reg, state_next;
    logic [N_W-1:0] n_reg, n_next;
    logic [K_W-1:0] k_reg, k_next;
    logic [M_W-1:0] m_reg, m_next;
    logic [P_W-1:0] p_reg, p_next;
    logic           at_last;

    // state and loop counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SEQ_IDLE;
            n_reg     <= '0;
            k_reg     <= '0;
            m_reg     <= '0;
            p_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
            k_reg     <= k_next;
            m_reg     <= m_next;
            p_reg     <= p_next;
        end
    end

    assign at_last = (k_reg == K_LAST) && (n_reg == N_LAST) &&
                     (m_reg == M_LAST) && (p_reg == p_top);

    // next state, counter stepping and outputs
    always_comb
    begin
        state_next  = state_reg;
        n_next      = n_reg;
        k_next      = k_reg;
        m_next      = m_reg;
        p_next      = p_reg;
        idle        = 1'b0;
        load        = 1'b0;
        cand.valid  = 1'b0;
        cand.last   = at_last;
        cand.n_code = n_reg;
        cand.k_code = k_reg;
        cand.m_code = m_reg;
        cand.p_code = p_reg;
        unique case (state_reg)
            SEQ_IDLE:
            begin
                idle = 1'b1;
                if (start)
                begin
                    n_next     = '0;
                    k_next     = '0;
                    m_next     = '0;
                    p_next     = '0;
                    state_next = SEQ_RUN;
                end
            end
            SEQ_RUN:
            begin
                cand.valid = 1'b1;
                // innermost P, then M, then N, then K
                if (p_reg == p_top)
                begin
                    p_next = '0;
                    if (m_reg == M_LAST)
                    begin
                        m_next = '0;
                        if (n_reg == N_LAST)
                        begin
                            n_next = '0;
                            k_next = k_reg + K_W'(1);
                        end
                        else
                        begin
                            n_next = n_reg + N_W'(1);
                        end
                    end
                    else
                    begin
                        m_next = m_reg + M_W'(1);
                    end
                end
                else
                begin
                    p_next = p_reg + P_W'(1);
                end
                if (at_last)
                begin
                    state_next = SEQ_WAIT;
                end
            end
            SEQ_WAIT:
            begin
                // pipeline drained and output register free
                if (done && out_free)
                begin
                    load       = 1'b1;
                    state_next = SEQ_IDLE;
                end
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/pfs_rate_unit.sv -----
// Shared rate unit: forms 24 MHz * N * K / (M * 2^P) for one candidate per
// cycle in two registered steps. Depends on pfs_pkg.
`timescale 1ns / 1ps

module pfs_rate_unit
    import pfs_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  cand_t cand,
    output rate_t rate_out
);

    cand_t             cand_reg;
    logic [BASE_W-1:0] base_reg;
    logic [NK_W-1:0]   nk_reg;
    logic [NK_W-1:0]   nk_next;
    logic [BASE_W+NK_W-1:0] prod;
    rate_t             rate_reg;

    assign nk_next = (NK_W'(cand.n_code) + NK_W'(1)) * (NK_W'(cand.k_code) + NK_W'(1));
    assign prod    = (BASE_W + NK_W)'(base_reg) * (BASE_W + NK_W)'(nk_reg);

    // first step: table lookup and N * K
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cand_reg <= '0;
            base_reg <= '0;
            nk_reg   <= '0;
        end
        else
        begin
            cand_reg <= cand;
            base_reg <= base_rate(cand.m_code, cand.p_code);
            nk_reg   <= nk_next;
        end
    end

    // second step: base times N * K, at most 3.072 GHz so 32 bits hold it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg <= '0;
        end
        else
        begin
            rate_reg.valid  <= cand_reg.valid;
            rate_reg.last   <= cand_reg.last;
            rate_reg.n_code <= cand_reg.n_code;
            rate_reg.k_code <= cand_reg.k_code;
            rate_reg.m_code <= cand_reg.m_code;
            rate_reg.p_code <= cand_reg.p_code;
            rate_reg.rate   <= prod[RATE_W-1:0];
        end
    end

    assign rate_out = rate_reg;

endmodule

// ----- hw/rtl/pfs_best.sv -----
// Best-fit tracker: keeps the highest rate not above the target, first one
// found wins on a tie. Depends on pfs_pkg.
`timescale 1ns / 1ps

module pfs_best
    import pfs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [RATE_W-1:0] target,
    input  rate_t             rate_in,
    output logic              done,
    output logic              found,
    output logic [N_W-1:0]    n_code,
    output logic [K_W-1:0]    k_code,
    output logic [M_W-1:0]    m_code,
    output logic [P_W-1:0]    p_code,
    output logic [RATE_W-1:0] rate
);

    logic              done_reg, found_reg;
    logic [N_W-1:0]    n_reg;
    logic [K_W-1:0]    k_reg;
    logic [M_W-1:0]    m_reg;
    logic [P_W-1:0]    p_reg;
    logic [RATE_W-1:0] rate_reg;
    logic              take;

    // candidate fits and beats what is held
    assign take = rate_in.valid && (rate_in.rate <= target) &&
                  (!found_reg || (rate_in.rate > rate_reg));

    // control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg  <= 1'b0;
            found_reg <= 1'b0;
        end
        else if (start)
        begin
            done_reg  <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            if (rate_in.valid && rate_in.last)
            begin
                done_reg <= 1'b1;
            end
            if (take)
            begin
                found_reg <= 1'b1;
            end
        end
    end

    // held best; cleared at start so no fit reads as all zero
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg    <= '0;
            k_reg    <= '0;
            m_reg    <= '0;
            p_reg    <= '0;
            rate_reg <= '0;
        end
        else if (take)
        begin
            n_reg    <= rate_in.n_code;
            k_reg    <= rate_in.k_code;
            m_reg    <= rate_in.m_code;
            p_reg    <= rate_in.p_code;
            rate_reg <= rate_in.rate;
        end
    end

    assign done   = done_reg;
    assign found  = found_reg;
    assign n_code = n_reg;
    assign k_code = k_reg;
    assign m_code = m_reg;
    assign p_code = p_reg;
    assign rate   = rate_reg;

endmodule
